// ===== hw/rtl/ldt_pkg.sv =====
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared types and codes for the local descriptor table unit.
// ----------------------------------------------------------------------------
package ldt_pkg;

  // function codes
  localparam logic [7:0] CMD_READ         = 8'h00;
  localparam logic [7:0] CMD_WRITE_LEGACY = 8'h01;
  localparam logic [7:0] CMD_WRITE_EXT    = 8'h11;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_UNSUPP  = 2'd2;

  localparam logic [15:0] WRITE_BYTES   = 16'd16;
  localparam logic [3:0]  DESC_BYTES    = 4'd8;
  localparam logic [15:0] FLAG_MASK_OUT = 16'hd0ff;
  localparam logic [15:0] FLAG_FIXED    = 16'h0070;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [15:0] entry_index;
    logic [15:0] byte_count;
    logic [31:0] seg_base;
    logic [19:0] seg_limit;
    logic        rx_only;
    logic [1:0]  contents;
    logic        not_present;
    logic        is_32bit;
    logic        page_granular;
    logic        usable_bit;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  bytes_returned;
    logic [31:0] word_low;
    logic [31:0] word_high;
    logic [1:0]  seg_kind;
  } rsp_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [31:0] base;
    logic [19:0] limit;
    logic [15:0] flags;
    logic [1:0]  kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // decoded request, decoder to control
  typedef struct packed {
    logic       mem_read;  // entry must be fetched
    logic       mem_write; // entry is stored
    logic [1:0] status;    // status when no fetch is needed
    logic [1:0] kind;      // kind reported when no fetch is needed
    entry_t     entry;     // entry to store
  } dec_t;

endpackage

// ===== hw/rtl/ldt_req_if.sv =====
// ----------------------------------------------------------------------------
// ldt_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface ldt_req_if;
  logic          valid;
  logic          ready;
  ldt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ldt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ldt_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface ldt_rsp_if;
  logic          valid;
  logic          ready;
  ldt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ldt_descriptor_table_unit.sv =====
// ----------------------------------------------------------------------------
// ldt_descriptor_table_unit
// Emulated x86 local descriptor table with x86 style read and write.
// ----------------------------------------------------------------------------
// The table lives in one single-port RAM of TABLE_ENTRIES entries, each
// holding base, 20-bit limit, attribute flags and segment kind. After reset
// the unit sweeps the RAM to zero, one entry per cycle, and takes no
// request word until the sweep is done. Then writes, rejected requests and
// unsupported functions go straight to the output register (the RAM write
// happens on the accepting edge), so they can be issued every cycle while
// the output register is free or being emptied. A fetching read holds off
// new requests in ST_FETCH until the RAM's registered data is loaded.
// Each request yields exactly one response word; the response sits in an
// output register, and a new request is taken as the old response is taken.
// ----------------------------------------------------------------------------
module ldt_descriptor_table_unit #(
  parameter int TABLE_ENTRIES = 8192,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic     clk,
  input  logic     rst,
  ldt_req_if.sink  req,
  ldt_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR,  // zeroing sweep after reset
    ST_RUN,    // taking requests
    ST_FETCH   // waiting for RAM read data
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   sweep_idx;
  logic               out_valid;
  ldt_pkg::rsp_t      out_data;

  ldt_pkg::dec_t      dec;
  logic               accept;
  logic               out_load;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  ldt_pkg::entry_t    ram_wdata;
  logic [ldt_pkg::ENTRY_W-1:0] ram_rdata;
  ldt_pkg::entry_t    rd_entry;
  ldt_pkg::rsp_t      fetch_rsp;
  ldt_pkg::rsp_t      direct_rsp;

  ldt_req_dec #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dec (
    .req (req.data),
    .dec (dec)
  );

  // accept only with the output register free, or freeing this cycle
  assign req.ready = (state == ST_RUN) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // output register takes a new word this cycle
  assign out_load  = (state == ST_FETCH) || (accept && !dec.mem_read);

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // the sweep owns the RAM port; otherwise the accepted request does
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = sweep_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && dec.mem_write;
      ram_addr  = req.data.entry_index[IDX_W-1:0];
      ram_wdata = dec.entry;
    end
  end

  ldt_ram #(
    .WIDTH(ldt_pkg::ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // pack the fetched entry as the two x86 descriptor words
  assign rd_entry = ram_rdata;

  always_comb begin
    fetch_rsp                = '0;
    fetch_rsp.status         = ldt_pkg::STATUS_OK;
    fetch_rsp.bytes_returned = ldt_pkg::DESC_BYTES;
    fetch_rsp.word_low       = {rd_entry.base[15:0], rd_entry.limit[15:0]};
    fetch_rsp.word_high      = (rd_entry.base & 32'hff00_0000)
                             | ((rd_entry.base & 32'h00ff_0000) >> 16)
                             | {12'd0, rd_entry.limit[19:16], 16'd0}
                             | ({16'd0, rd_entry.flags & ldt_pkg::FLAG_MASK_OUT} << 8);
    fetch_rsp.seg_kind       = rd_entry.kind;
  end

  // writes and status-only results carry no descriptor words
  always_comb begin
    direct_rsp          = '0;
    direct_rsp.status   = dec.status;
    direct_rsp.seg_kind = dec.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (sweep_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
            state <= ST_RUN;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        ST_RUN: begin
          if (accept) begin
            if (dec.mem_read) begin
              state <= ST_FETCH;
            end else begin
              out_valid <= 1'b1;
              out_data  <= direct_rsp;
            end
          end
        end
        ST_FETCH: begin
          out_valid <= 1'b1;
          out_data  <= fetch_rsp;
          state     <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ldt_ram.sv =====
// ----------------------------------------------------------------------------
// ldt_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module ldt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/ldt_req_dec.sv =====
// ----------------------------------------------------------------------------
// ldt_req_dec
// Request checker: validates a request and builds the entry to store.
// ----------------------------------------------------------------------------
module ldt_req_dec #(
  parameter int TABLE_ENTRIES = 8192
) (
  input  ldt_pkg::req_t req,
  output ldt_pkg::dec_t dec
);

  logic        in_range;
  logic        ext;
  logic        bad_write;
  logic [15:0] flags;

  assign in_range = {1'b0, req.entry_index} < 17'(TABLE_ENTRIES);
  assign ext      = (req.cmd == ldt_pkg::CMD_WRITE_EXT);

  // conforming code must be extended mode and not present
  assign bad_write = (req.byte_count != ldt_pkg::WRITE_BYTES) || !in_range ||
                     ((req.contents == 2'd3) && (!ext || !req.not_present));

  assign flags = {req.page_granular, req.is_32bit, 1'b0, req.usable_bit & ext,
                  4'b0000, ~req.not_present, 3'b000, req.contents,
                  ~req.rx_only, 1'b0} | ldt_pkg::FLAG_FIXED;

  always_comb begin
    dec             = '0;
    dec.entry.base  = req.seg_base;
    dec.entry.limit = req.seg_limit;
    dec.entry.flags = flags;
    dec.entry.kind  = {req.contents[1], req.is_32bit};
    unique case (req.cmd)
      ldt_pkg::CMD_READ: begin
        if (req.byte_count == 16'd0) begin
          dec.status = ldt_pkg::STATUS_OK;
        end else if (!in_range) begin
          dec.status = ldt_pkg::STATUS_INVALID;
        end else begin
          dec.mem_read = 1'b1;
        end
      end
      ldt_pkg::CMD_WRITE_LEGACY, ldt_pkg::CMD_WRITE_EXT: begin
        if (bad_write) begin
          dec.status = ldt_pkg::STATUS_INVALID;
        end else begin
          dec.mem_write = 1'b1;
          dec.status    = ldt_pkg::STATUS_OK;
          dec.kind      = {req.contents[1], req.is_32bit};
        end
      end
      default: begin
        dec.status = ldt_pkg::STATUS_UNSUPP;
      end
    endcase
  end

endmodule

// ===== sim/ldt_descriptor_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// ldt_descriptor_table_unit_test
// Self-checking bench for the descriptor table: drives read, write and
// unsupported requests with random pacing, and compares every response word
// against a shadow copy of the table.
// ----------------------------------------------------------------------------
module ldt_descriptor_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES    = 8192;
  localparam int RANDOM_REQ = 1050;

  // --------------------------------------------------------------------------
  // Shadow table: tracks what the unit should hold and queues the response
  // word each accepted request must produce, in issue order.
  // --------------------------------------------------------------------------
  class descriptor_shadow;
    logic [31:0]   base_tbl  [ENTRIES];
    logic [19:0]   limit_tbl [ENTRIES];
    logic [15:0]   flags_tbl [ENTRIES];
    logic [1:0]    kind_tbl  [ENTRIES];
    ldt_pkg::rsp_t pending_responses[$];
    int            mismatches;
    int            checked;

    function new();
      foreach (base_tbl[i]) begin
        base_tbl[i]  = '0;
        limit_tbl[i] = '0;
        flags_tbl[i] = '0;
        kind_tbl[i]  = '0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] response %0d: %s", $realtime, checked, what);
      mismatches++;
    endtask

    // Work out the response for one accepted request and apply its write.
    function void note_request(ldt_pkg::req_t r);
      ldt_pkg::rsp_t o;
      logic          legacy;
      logic [15:0]   flags;
      logic [31:0]   b;
      logic [19:0]   l;
      o = '0;
      case (r.cmd)
        ldt_pkg::CMD_READ: begin
          if (r.byte_count == 16'd0) begin
            // zero-length read: ok status, nothing returned
          end else if (r.entry_index >= ENTRIES) begin
            o.status = ldt_pkg::STATUS_INVALID;
          end else begin
            b = base_tbl[r.entry_index];
            l = limit_tbl[r.entry_index];
            flags = flags_tbl[r.entry_index] & ldt_pkg::FLAG_MASK_OUT;
            o.status         = ldt_pkg::STATUS_OK;
            o.bytes_returned = ldt_pkg::DESC_BYTES;
            o.word_low       = {b[15:0], l[15:0]};
            o.word_high      = (b & 32'hff00_0000) | {24'd0, b[23:16]} |
                               {12'd0, l[19:16], 16'd0} | ({16'd0, flags} << 8);
            o.seg_kind       = kind_tbl[r.entry_index];
          end
        end
        ldt_pkg::CMD_WRITE_LEGACY, ldt_pkg::CMD_WRITE_EXT: begin
          legacy = (r.cmd == ldt_pkg::CMD_WRITE_LEGACY);
          if (r.byte_count != ldt_pkg::WRITE_BYTES || r.entry_index >= ENTRIES ||
              (r.contents == 2'd3 && (legacy || !r.not_present))) begin
            o.status = ldt_pkg::STATUS_INVALID;
          end else begin
            flags     = ldt_pkg::FLAG_FIXED;
            flags[1]  = ~r.rx_only;
            flags[3:2] = r.contents;
            flags[7]  = ~r.not_present;
            flags[14] = r.is_32bit;
            flags[15] = r.page_granular;
            if (!legacy)
              flags[12] = r.usable_bit;
            base_tbl[r.entry_index]  = r.seg_base;
            limit_tbl[r.entry_index] = r.seg_limit;
            flags_tbl[r.entry_index] = flags;
            // code when contents >= 2, 32-bit from is_32bit
            kind_tbl[r.entry_index]  = {r.contents[1], r.is_32bit};
            o.seg_kind = {r.contents[1], r.is_32bit};
          end
        end
        default: o.status = ldt_pkg::STATUS_UNSUPP;
      endcase
      pending_responses.push_back(o);
    endfunction

    task check_response(ldt_pkg::rsp_t got);
      ldt_pkg::rsp_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response %h", got));
        checked++;
        return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.bytes_returned !== want.bytes_returned)
        report_mismatch($sformatf("bytes_returned %0d, want %0d",
                                  got.bytes_returned, want.bytes_returned));
      if (got.word_low !== want.word_low)
        report_mismatch($sformatf("word_low %h, want %h", got.word_low, want.word_low));
      if (got.word_high !== want.word_high)
        report_mismatch($sformatf("word_high %h, want %h", got.word_high, want.word_high));
      if (got.seg_kind !== want.seg_kind)
        report_mismatch($sformatf("seg_kind %0d, want %0d", got.seg_kind, want.seg_kind));
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the unit under test
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  ldt_req_if req_ch ();
  ldt_rsp_if rsp_ch ();

  ldt_descriptor_table_unit #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  descriptor_shadow board = new();

  int sent_count      = 0;
  // set by the request side, consumed by the response side: a long stretch
  // with ready low so the output register fills and the unit stops taking
  // requests while the sender keeps valid up
  int hold_off_cycles = 0;

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rsp_ch.ready <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Request helpers
  // --------------------------------------------------------------------------
  function automatic ldt_pkg::req_t build_req(logic [7:0] cmd, logic [15:0] idx,
                                              logic [15:0] cnt, logic [31:0] base,
                                              logic [19:0] lim, logic rxo,
                                              logic [1:0] cont, logic np, logic b32,
                                              logic pg, logic usable);
    ldt_pkg::req_t r;
    r.cmd            = cmd;
    r.entry_index    = idx;
    r.byte_count     = cnt;
    r.seg_base       = base;
    r.seg_limit      = lim;
    r.rx_only        = rxo;
    r.contents       = cont;
    r.not_present    = np;
    r.is_32bit       = b32;
    r.page_granular  = pg;
    r.usable_bit     = usable;
    return r;
  endfunction

  // Mostly a small hot set so reads find written entries; some top-of-table
  // hits, some anywhere in range, some over the full 16-bit field.
  function automatic logic [15:0] pick_index();
    bit [31:0] rnd;
    rnd = $urandom();
    case (rnd[31:29])
      3'd0:    return rnd[15:0];
      3'd1:    return 16'(ENTRIES - 32) + {11'd0, rnd[4:0]};
      3'd2:    return {3'd0, rnd[12:0]};
      default: return {11'd0, rnd[4:0]};
    endcase
  endfunction

  function automatic ldt_pkg::req_t make_random_request();
    ldt_pkg::req_t r;
    bit [31:0]     rnd;
    bit [31:0]     rnd2;
    int            pick;
    pick = $urandom_range(0, 99);
    rnd  = $urandom();
    rnd2 = $urandom();
    r.seg_base       = $urandom();
    r.seg_limit      = rnd2[19:0];
    r.rx_only        = rnd[0];
    r.contents       = rnd[2:1];
    r.not_present    = rnd[3];
    r.is_32bit       = rnd[4];
    r.page_granular  = rnd[5];
    r.usable_bit     = rnd[6];
    r.entry_index    = pick_index();
    if (pick < 40) begin
      // well-formed write; conforming code usually given a legal shape
      r.cmd        = rnd[7] ? ldt_pkg::CMD_WRITE_EXT : ldt_pkg::CMD_WRITE_LEGACY;
      r.byte_count = ldt_pkg::WRITE_BYTES;
      if (r.contents == 2'd3 && rnd[8]) begin
        r.cmd         = ldt_pkg::CMD_WRITE_EXT;
        r.not_present = 1'b1;
      end
    end else if (pick < 75) begin
      r.cmd = ldt_pkg::CMD_READ;
      case (rnd[10:9])
        2'd0:    r.byte_count = 16'd0;
        2'd1:    r.byte_count = 16'(ldt_pkg::DESC_BYTES);
        default: r.byte_count = (rnd[31:16] == 16'd0) ? 16'd1 : rnd[31:16];
      endcase
    end else if (pick < 88) begin
      // write of odd size (rarely the right one)
      r.cmd        = rnd[7] ? ldt_pkg::CMD_WRITE_EXT : ldt_pkg::CMD_WRITE_LEGACY;
      r.byte_count = rnd[31:16];
      if (rnd[11])
        r.byte_count = ldt_pkg::WRITE_BYTES + {12'd0, rnd[15:12]} - 16'd8;
    end else begin
      // raw noise: any function code and size
      r.cmd         = rnd2[27:20];
      r.byte_count  = rnd[31:16];
      r.entry_index = rnd2[31:16];
    end
    return r;
  endfunction

  // One request: random gap with valid low, then hold it up until taken.
  // valid is only lowered when a gap follows, so back-to-back words never
  // see a low and a high write to valid in the same step.
  task automatic send_request(input ldt_pkg::req_t r);
    int gap;
    gap = ((sent_count / 128) % 3 == 2) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(r);
    sent_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  initial begin : request_source
    ldt_pkg::req_t directed[$];
    int            n;

    // directed set: table extremes, every function, each rejection rule
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd0, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // legal conforming code: extended, not present, every bit set
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_EXT, 16'd0, ldt_pkg::WRITE_BYTES,
                                 32'hffff_ffff, 20'hfffff, 1'b1, 2'd3, 1'b1, 1'b1,
                                 1'b1, 1'b1));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd0, 16'd1, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // legacy write drops the usable bit
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_LEGACY, 16'(ENTRIES - 1),
                                 ldt_pkg::WRITE_BYTES, 32'h0, 20'h0, 1'b0, 2'd0,
                                 1'b0, 1'b0, 1'b0, 1'b1));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'(ENTRIES - 1), 16'hffff,
                                 32'h0, 20'h0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // zero-length read
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd0, 16'd0, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // reads past the table
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'(ENTRIES), 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'hffff, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // wrong write sizes
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_EXT, 16'd5, 16'd15, 32'h1234_5678,
                                 20'h12345, 1'b0, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_LEGACY, 16'd5, 16'd17,
                                 32'h1234_5678, 20'h12345, 1'b0, 2'd1, 1'b0, 1'b1,
                                 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd5, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // write past the table
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_EXT, 16'(ENTRIES),
                                 ldt_pkg::WRITE_BYTES, 32'h8765_4321, 20'h54321,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // conforming code rejected: legacy, then extended but present
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_LEGACY, 16'd6, ldt_pkg::WRITE_BYTES,
                                 32'hdead_beef, 20'h0beef, 1'b0, 2'd3, 1'b1, 1'b1,
                                 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_EXT, 16'd6, ldt_pkg::WRITE_BYTES,
                                 32'hdead_beef, 20'h0beef, 1'b0, 2'd3, 1'b0, 1'b1,
                                 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd6, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // segment kinds 16-bit code, 32-bit data and 32-bit code
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_EXT, 16'd2, ldt_pkg::WRITE_BYTES,
                                 32'h00a1_b2c3, 20'h00fff, 1'b0, 2'd2, 1'b0, 1'b0,
                                 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd2, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_EXT, 16'd3, ldt_pkg::WRITE_BYTES,
                                 32'h5a5a_a5a5, 20'ha5a5a, 1'b1, 2'd1, 1'b0, 1'b1,
                                 1'b1, 1'b1));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd3, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_WRITE_LEGACY, 16'd4, ldt_pkg::WRITE_BYTES,
                                 32'h0102_0304, 20'h50607, 1'b0, 2'd2, 1'b1, 1'b1,
                                 1'b0, 1'b0));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd4, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    // unsupported function codes
    directed.push_back(build_req(8'h02, 16'd0, ldt_pkg::WRITE_BYTES, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    directed.push_back(build_req(8'h10, 16'd1, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    directed.push_back(build_req(8'hff, 16'hffff, 16'hffff, 32'hffff_ffff, 20'hfffff,
                                 1'b1, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1));
    directed.push_back(build_req(ldt_pkg::CMD_READ, 16'd0, 16'd8, 32'h0, 20'h0,
                                 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // the unit clears its table after reset; the first word simply waits
    // on ready until the sweep is done
    foreach (directed[i])
      send_request(directed[i]);

    for (n = 0; n < RANDOM_REQ; n++) begin
      if (n == 300)
        hold_off_cycles = 80;
      else if (n == 750)
        hold_off_cycles = 40;
      send_request(make_random_request());
    end
    req_ch.valid <= 1'b0;

    // drain, then a further wait to catch any stray response word
    while (board.pending_responses.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (board.mismatches == 0 && board.pending_responses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: random stalls, stretches with ready held high, and the
  // long hold-off requested by the request side
  // --------------------------------------------------------------------------
  initial begin : response_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else if ((taken / 100) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      board.check_response(rsp_ch.data);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: far beyond the reset sweep plus every word at its worst pacing
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== ldt_descriptor_table_unit.f =====
hw/rtl/ldt_pkg.sv
hw/rtl/ldt_req_if.sv
hw/rtl/ldt_rsp_if.sv
hw/rtl/ldt_ram.sv
hw/rtl/ldt_req_dec.sv
hw/rtl/ldt_descriptor_table_unit.sv
sim/ldt_descriptor_table_unit_test.sv
